// ----- rtl/sorted_key_index_table_unit_macros.svh -----
// Assertion macros for the sorted key index table unit.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef SORTED_KEY_INDEX_TABLE_UNIT_MACROS_SVH
`define SORTED_KEY_INDEX_TABLE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define SKIT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("skit check failed");
// Next-cycle implication, disabled during reset.
`define SKIT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("skit check failed");
`else
`define SKIT_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define SKIT_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/skit_pkg.sv -----
// Shared types and codes for the sorted key index table unit.
// Used by skit_ctrl, skit_dpath and the top level; no dependencies.
package skit_pkg;

   localparam int KEY_W    = 32;
   localparam int REC_W    = 31;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;
   localparam int FOUND_W  = 32;
   localparam int COUNT_W  = 9;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 48;

   // Operation kinds
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

   // Datapath operations issued by the controller
   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,     // latch request, open search over [0, count)
      DP_RD_MID,   // read the probe entry of the search window
      DP_STEP,     // compare probe entry, narrow the window
      DP_SAVE_LB,  // keep lower bound, reopen window up to count
      DP_INS_INIT, // shift pointer to the end of the table
      DP_RD_PTRM1, // read the entry below the shift pointer
      DP_WR_UP,    // move it up one slot
      DP_WR_NEW,   // write the new pair at the insert position
      DP_RM_INIT,  // source at upper bound, destination at lower bound
      DP_RD_SRC,   // read the source entry
      DP_WR_DN,    // move it down to the destination
      DP_RM_DONE,  // new count is the destination index
      DP_RESULT    // load the result register
   } dp_op_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [REC_W-1:0] rec;
   } entry_type;

   typedef struct packed {
      dp_op_type           op;
      logic                upper;    // search for first key greater than
      logic [STATUS_W-1:0] status;
      logic                found_en;
   } dp_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              search_open;
      logic              shift_up_open;
      logic              shift_dn_open;
      logic              full;
      logic              hit;
      logic              no_match;
   } dp_stat_type;

endpackage

// ----- rtl/skit_ctrl.sv -----
// Controller state machine for the sorted key index table unit.
// Depends on skit_pkg and the assertion macro header.
`include "sorted_key_index_table_unit_macros.svh"
module skit_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  skit_pkg::dp_stat_type  stat,
   output skit_pkg::dp_cmd_type   cmd
);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_DISPATCH = 4'd1;
   localparam logic [3:0] ST_SRCH_RD  = 4'd2;
   localparam logic [3:0] ST_SRCH_CMP = 4'd3;
   localparam logic [3:0] ST_UP_RD    = 4'd4;
   localparam logic [3:0] ST_UP_WR    = 4'd5;
   localparam logic [3:0] ST_DN_RD    = 4'd6;
   localparam logic [3:0] ST_DN_WR    = 4'd7;
   localparam logic [3:0] ST_FINISH   = 4'd8;

   logic [3:0]                    state_ff, state_in;
   logic                          phase_ff, phase_in;
   logic [skit_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic                          res_found_ff, res_found_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      cmd.op        = skit_pkg::DP_NOP;
      cmd.upper     = phase_ff;
      cmd.status    = res_status_ff;
      cmd.found_en  = res_found_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = skit_pkg::DP_LOAD;
               phase_in = 1'b0;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (stat.kind)
               skit_pkg::KIND_INSERT: begin
                  if (stat.full) begin
                     res_status_in = skit_pkg::ST_FULL;
                     res_found_in  = 1'b0;
                     state_in      = ST_FINISH;
                  end else begin
                     phase_in = 1'b1;
                     state_in = ST_SRCH_RD;
                  end
               end
               skit_pkg::KIND_REMOVE, skit_pkg::KIND_LOOKUP: begin
                  phase_in = 1'b0;
                  state_in = ST_SRCH_RD;
               end
               default: begin
                  res_status_in = skit_pkg::ST_OK;
                  res_found_in  = 1'b0;
                  state_in      = ST_FINISH;
               end
            endcase
         end
         ST_SRCH_RD: begin
            if (stat.search_open) begin
               cmd.op   = skit_pkg::DP_RD_MID;
               state_in = ST_SRCH_CMP;
            end else begin
               case (stat.kind)
                  skit_pkg::KIND_LOOKUP: begin
                     res_status_in = stat.hit ? skit_pkg::ST_OK : skit_pkg::ST_NOT_FOUND;
                     res_found_in  = stat.hit;
                     state_in      = ST_FINISH;
                  end
                  skit_pkg::KIND_REMOVE: begin
                     if (!phase_ff) begin
                        cmd.op   = skit_pkg::DP_SAVE_LB;
                        phase_in = 1'b1;
                     end else if (stat.no_match) begin
                        res_status_in = skit_pkg::ST_NOT_FOUND;
                        res_found_in  = 1'b0;
                        state_in      = ST_FINISH;
                     end else begin
                        cmd.op   = skit_pkg::DP_RM_INIT;
                        state_in = ST_DN_RD;
                     end
                  end
                  default: begin
                     cmd.op   = skit_pkg::DP_INS_INIT;
                     state_in = ST_UP_RD;
                  end
               endcase
            end
         end
         ST_SRCH_CMP: begin
            cmd.op   = skit_pkg::DP_STEP;
            state_in = ST_SRCH_RD;
         end
         ST_UP_RD: begin
            if (stat.shift_up_open) begin
               cmd.op   = skit_pkg::DP_RD_PTRM1;
               state_in = ST_UP_WR;
            end else begin
               cmd.op        = skit_pkg::DP_WR_NEW;
               res_status_in = skit_pkg::ST_OK;
               res_found_in  = 1'b0;
               state_in      = ST_FINISH;
            end
         end
         ST_UP_WR: begin
            cmd.op   = skit_pkg::DP_WR_UP;
            state_in = ST_UP_RD;
         end
         ST_DN_RD: begin
            if (stat.shift_dn_open) begin
               cmd.op   = skit_pkg::DP_RD_SRC;
               state_in = ST_DN_WR;
            end else begin
               cmd.op        = skit_pkg::DP_RM_DONE;
               res_status_in = skit_pkg::ST_OK;
               res_found_in  = 1'b0;
               state_in      = ST_FINISH;
            end
         end
         ST_DN_WR: begin
            cmd.op   = skit_pkg::DP_WR_DN;
            state_in = ST_DN_RD;
         end
         ST_FINISH: begin
            // wait for the result register to drain
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.op       = skit_pkg::DP_RESULT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   `SKIT_ASSERT_IMPL(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_FINISH)
   `SKIT_ASSERT_NEXT(a_finish_waits, clock, reset, (state_ff == ST_FINISH) && rsp_valid_ff && !rsp_tready, state_ff == ST_FINISH)
   `SKIT_ASSERT_NEXT(a_load_dispatch, clock, reset, cmd.op == skit_pkg::DP_LOAD, state_ff == ST_DISPATCH)

endmodule

// ----- rtl/skit_dpath.sv -----
// Datapath of the sorted key index table unit: entry memory, search window,
// shift pointers, entry count and result register. Depends on skit_pkg and the macro header.
`include "sorted_key_index_table_unit_macros.svh"
module skit_dpath #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [skit_pkg::KIND_W-1:0]      req_kind,
   input  logic [skit_pkg::KEY_W-1:0]       req_key,
   input  logic [skit_pkg::REC_W-1:0]       req_rec,
   input  skit_pkg::dp_cmd_type             cmd,
   output skit_pkg::dp_stat_type            stat,
   output logic [skit_pkg::STATUS_W-1:0]    rsp_status,
   output logic [skit_pkg::FOUND_W-1:0]     rsp_found,
   output logic [skit_pkg::COUNT_W-1:0]     rsp_count
);

   localparam int IDX_W  = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);
   localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(TABLE_DEPTH);

   skit_pkg::entry_type mem [TABLE_DEPTH];

   logic [skit_pkg::KIND_W-1:0]   kind_ff;
   logic [skit_pkg::KEY_W-1:0]    key_ff;
   logic [skit_pkg::REC_W-1:0]    rec_ff;
   logic [IDX_W-1:0]              lo_ff, hi_ff, lb_ff, ptr_ff, src_ff, dst_ff, count_ff;
   logic                          hit_ff;
   logic [skit_pkg::REC_W-1:0]    found_rec_ff;
   skit_pkg::entry_type           rd_data_ff;
   logic [skit_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [skit_pkg::FOUND_W-1:0]  rsp_found_ff;
   logic [skit_pkg::COUNT_W-1:0]  rsp_count_ff;

   logic [IDX_W:0]                mid_sum;
   logic [IDX_W-1:0]              mid;
   logic [IDX_W-1:0]              ptr_dec;
   logic                          pred;
   logic                          rd_en;
   logic [ADDR_W-1:0]             rd_addr;
   logic                          wr_en;
   logic [ADDR_W-1:0]             wr_addr;
   skit_pkg::entry_type           wr_data;
   logic [IDX_W+skit_pkg::COUNT_W-1:0] count_ext;

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[IDX_W:1];
   assign ptr_dec = ptr_ff - IDX_ONE;

   // upper search: first key greater; lower search: first key not less
   assign pred = cmd.upper ? ($signed(rd_data_ff.key) >  $signed(key_ff))
                           : ($signed(rd_data_ff.key) >= $signed(key_ff));

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = mid[ADDR_W-1:0];
      case (cmd.op)
         skit_pkg::DP_RD_MID: begin
            rd_en   = 1'b1;
            rd_addr = mid[ADDR_W-1:0];
         end
         skit_pkg::DP_RD_PTRM1: begin
            rd_en   = 1'b1;
            rd_addr = ptr_dec[ADDR_W-1:0];
         end
         skit_pkg::DP_RD_SRC: begin
            rd_en   = 1'b1;
            rd_addr = src_ff[ADDR_W-1:0];
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ptr_ff[ADDR_W-1:0];
      wr_data = rd_data_ff;
      case (cmd.op)
         skit_pkg::DP_WR_UP: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff[ADDR_W-1:0];
         end
         skit_pkg::DP_WR_NEW: begin
            wr_en       = 1'b1;
            wr_addr     = lo_ff[ADDR_W-1:0];
            wr_data.key = key_ff;
            wr_data.rec = rec_ff;
         end
         skit_pkg::DP_WR_DN: begin
            wr_en   = 1'b1;
            wr_addr = dst_ff[ADDR_W-1:0];
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // window bounds and count are control state
   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff    <= '0;
         hi_ff    <= '0;
         count_ff <= '0;
      end else begin
         case (cmd.op)
            skit_pkg::DP_LOAD: begin
               lo_ff <= '0;
               hi_ff <= count_ff;
            end
            skit_pkg::DP_STEP: begin
               if (pred) begin
                  hi_ff <= mid;
               end else begin
                  lo_ff <= mid + IDX_ONE;
               end
            end
            skit_pkg::DP_SAVE_LB: begin
               hi_ff <= count_ff;
            end
            skit_pkg::DP_WR_NEW: begin
               count_ff <= count_ff + IDX_ONE;
            end
            skit_pkg::DP_RM_DONE: begin
               count_ff <= dst_ff;
            end
            default: begin
               lo_ff <= lo_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         skit_pkg::DP_LOAD: begin
            kind_ff <= req_kind;
            key_ff  <= req_key;
            rec_ff  <= req_rec;
            hit_ff  <= 1'b0;
         end
         skit_pkg::DP_STEP: begin
            // last probe that closed the window is the bound's entry
            if (pred) begin
               hit_ff       <= (rd_data_ff.key == key_ff);
               found_rec_ff <= rd_data_ff.rec;
            end
         end
         skit_pkg::DP_SAVE_LB: begin
            lb_ff <= lo_ff;
         end
         skit_pkg::DP_INS_INIT: begin
            ptr_ff <= count_ff;
         end
         skit_pkg::DP_WR_UP: begin
            ptr_ff <= ptr_dec;
         end
         skit_pkg::DP_RM_INIT: begin
            src_ff <= lo_ff;
            dst_ff <= lb_ff;
         end
         skit_pkg::DP_WR_DN: begin
            src_ff <= src_ff + IDX_ONE;
            dst_ff <= dst_ff + IDX_ONE;
         end
         skit_pkg::DP_RESULT: begin
            rsp_status_ff <= cmd.status;
            rsp_found_ff  <= cmd.found_en ? {1'b0, found_rec_ff} : '1;
            rsp_count_ff  <= count_ext[skit_pkg::COUNT_W-1:0];
         end
         default: begin
            kind_ff <= kind_ff;
         end
      endcase
   end

   assign count_ext = {{skit_pkg::COUNT_W{1'b0}}, count_ff};

   assign stat.kind          = kind_ff;
   assign stat.search_open   = (lo_ff < hi_ff);
   assign stat.shift_up_open = (ptr_ff > lo_ff);
   assign stat.shift_dn_open = (src_ff < count_ff);
   assign stat.full          = (count_ff == IDX_MAX);
   assign stat.hit           = hit_ff;
   assign stat.no_match      = (lb_ff == lo_ff);

   assign rsp_status = rsp_status_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_count  = rsp_count_ff;

   `SKIT_ASSERT_IMPL(a_window_order, clock, reset, 1'b1, lo_ff <= hi_ff)
   `SKIT_ASSERT_IMPL(a_compact_order, clock, reset, cmd.op == skit_pkg::DP_WR_DN, dst_ff < src_ff)
   `SKIT_ASSERT_NEXT(a_insert_count, clock, reset, cmd.op == skit_pkg::DP_WR_NEW, count_ff == $past(count_ff) + IDX_ONE)

endmodule

// ----- rtl/sorted_key_index_table_unit.sv -----
// Sorted key index table unit: keeps up to TABLE_DEPTH (key, record number)
// pairs in ascending signed key order in an entry memory that is never read
// and written together, and serves insert, remove-all-matching and lookup
// requests, one beat in and one result beat out per request. Insert
// binary-searches for the first key greater than the request key (equal keys
// land after existing ones), moves the tail up one slot and writes the pair;
// lookup binary-searches for the first key not less than the request key;
// remove finds both bounds of the matching run and moves the tail down over
// it. Each search probe is a memory read followed by a compare, and each
// moved entry a read followed by a write, so the number of probes and the
// length of the moved tail set how long a request runs. An insert against a
// full table or an unused kind skips the search and goes straight to the
// result. The controller is idle again as the result is loaded, so the next
// request beat can be taken in the following cycle at the earliest. A result
// still waiting on rsp_tready holds the next one back until it is taken. No
// clearing pass follows reset: only entries below the entry count are ever
// read. The result beat sits in an output register, so a new request beat is
// taken while the previous result still waits on rsp_tready.
// Depends on skit_pkg, skit_ctrl and skit_dpath.
module sorted_key_index_table_unit #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [skit_pkg::REQ_DATA_W-1:0]   req_tdata,  // key[31:0], record_number[62:32], zero[63]
   input  logic [skit_pkg::KIND_W-1:0]       req_tuser,  // kind[1:0]
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [skit_pkg::RSP_DATA_W-1:0]   rsp_tdata   // status[1:0], found_record[33:2],
                                                         // entry_count[42:34], zero[47:43]
);

   skit_pkg::dp_cmd_type          cmd;
   skit_pkg::dp_stat_type         stat;
   logic [skit_pkg::STATUS_W-1:0] rsp_status;
   logic [skit_pkg::FOUND_W-1:0]  rsp_found;
   logic [skit_pkg::COUNT_W-1:0]  rsp_count;

   // Sequence each request: dispatch on kind, run the searches, drive the
   // tail moves, then hand the result to the output register.
   skit_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Hold the entries, the search window and the result payload.
   skit_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_kind   (req_tuser),
      .req_key    (req_tdata[31:0]),
      .req_rec    (req_tdata[62:32]),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_status (rsp_status),
      .rsp_found  (rsp_found),
      .rsp_count  (rsp_count)
   );

   // Pack the result beat, lowest field first, zero fill to whole bytes.
   assign rsp_tdata = {5'b0, rsp_count, rsp_found, rsp_status};

endmodule
